// ----- rtl/urac_pkg.sv -----
`timescale 1ns / 1ps

package urac_pkg;

  // Round-trip echo time per centimetre of range
  localparam logic [15:0] US_PER_CM = 16'd58;

  // Register reset values
  localparam logic [9:0]  RST_FWD_STOP_CM  = 10'd10;
  localparam logic [9:0]  RST_BWD_CLEAR_CM = 10'd15;
  localparam logic [23:0] RST_SETTLE_US    = 24'd1000000;
  localparam logic [9:0]  RST_PULSE_US     = 10'd10;

  // floor(w / 58) as (w * DIV_MUL) >> DIV_SHIFT, exact for w below DIST_SAT_W
  localparam logic [17:0] DIV_MUL    = 18'd144632;
  localparam int          DIV_SHIFT  = 23;
  localparam logic [16:0] DIST_SAT_W = 17'd118784;  // 2048 * 58
  localparam logic [10:0] DIST_MAX   = 11'd2047;

  typedef enum logic [1:0] {
    DRV_NONE = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2,
    DRV_STOP = 2'd3
  } drive_t;

  // Configuration as seen by the ranging core: thresholds already in echo ticks,
  // phase lengths already forced to at least one tick.
  typedef struct packed {
    logic [15:0] fwd_thr;
    logic [15:0] bwd_thr;
    logic [23:0] settle_need;
    logic [9:0]  pulse_need;
  } cfg_t;

  typedef struct packed {
    logic        trigger;
    drive_t      drive;
    logic        arrived;
    logic [10:0] dist_cm;
    logic        dist_valid;
    logic        busy;
  } res_t;

endpackage

// ----- rtl/ultrasonic_range_approach_controller.sv -----
`timescale 1ns / 1ps
// A tick accepted into the input register passes through the sequencer into the result register, shown at out_valid.
// Throughput: one tick transaction per clock; only a stalled result register holds the input.
// Timing is set by one pass through the phase sequencer and the width/58 multiply.
// Reset (rst_n low, synchronous): sequencer idle, distance 0, both pipeline stages
// empty, registers back to 10 cm / 15 cm / 1000000 us / 10 us.

module ultrasonic_range_approach_controller #(
  parameter int ECHO_BITS  = 16,
  parameter int TIMER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_echo_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_trigger_level,
  output logic [1:0]  out_drive_cmd,
  output logic        out_arrived,
  output logic [10:0] out_distance_cm,
  output logic        out_distance_valid,
  output logic        out_busy_res,
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  urac_pkg::cfg_t cfg;
  urac_pkg::res_t res;
  urac_pkg::res_t out_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_func_r;
  logic       s1_echo_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  // Tick in the input register moves through the sequencer into the result register
  assign s1_adv   = s1_valid_r && out_free;
  // Input register only blocks when it is full and cannot move on
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_echo_r <= in_echo_level;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  urac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer state only moves when a tick transaction passes through
  urac_core #(
    .ECHO_BITS  (ECHO_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .func  (s1_func_r),
    .echo  (s1_echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid          = out_valid_r;
  assign out_trigger_level  = out_r.trigger;
  assign out_drive_cmd      = out_r.drive;
  assign out_arrived        = out_r.arrived;
  assign out_distance_cm    = out_r.dist_cm;
  assign out_distance_valid = out_r.dist_valid;
  assign out_busy_res       = out_r.busy;

endmodule

// ----- rtl/urac_cfg.sv -----
`timescale 1ns / 1ps

module urac_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output urac_pkg::cfg_t      cfg
);

  typedef enum logic [1:0] {
    REG_FWD_STOP  = 2'd0,
    REG_BWD_CLEAR = 2'd1,
    REG_SETTLE    = 2'd2,
    REG_PULSE     = 2'd3
  } reg_idx_t;

  localparam logic [15:0] RST_FWD_THR =
    16'(urac_pkg::RST_FWD_STOP_CM) * urac_pkg::US_PER_CM;
  localparam logic [15:0] RST_BWD_THR =
    16'(urac_pkg::RST_BWD_CLEAR_CM) * urac_pkg::US_PER_CM;

  urac_pkg::cfg_t cfg_r;
  logic [15:0]    thr_nxt;
  logic [23:0]    settle_nxt;
  logic [9:0]     pulse_nxt;

  // cm -> echo ticks, zero length -> one tick
  assign thr_nxt    = 16'(cfg_data[9:0]) * urac_pkg::US_PER_CM;
  assign settle_nxt = (cfg_data == 24'd0) ? 24'd1 : cfg_data;
  assign pulse_nxt  = (cfg_data[9:0] == 10'd0) ? 10'd1 : cfg_data[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_thr     <= RST_FWD_THR;
      cfg_r.bwd_thr     <= RST_BWD_THR;
      cfg_r.settle_need <= urac_pkg::RST_SETTLE_US;
      cfg_r.pulse_need  <= urac_pkg::RST_PULSE_US;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FWD_STOP:  cfg_r.fwd_thr     <= thr_nxt;
        REG_BWD_CLEAR: cfg_r.bwd_thr     <= thr_nxt;
        REG_SETTLE:    cfg_r.settle_need <= settle_nxt;
        REG_PULSE:     cfg_r.pulse_need  <= pulse_nxt;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/urac_core.sv -----
`timescale 1ns / 1ps

module urac_core #(
  parameter int ECHO_BITS  = 16,
  parameter int TIMER_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic [1:0]     func,
  input  logic           echo,
  input  urac_pkg::cfg_t cfg,
  output urac_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_PULSE   = 3'd2,
    PH_WAIT    = 3'd3,
    PH_MEASURE = 3'd4
  } phase_t;

  localparam logic [1:0] FUNC_FWD = 2'd1;
  localparam logic [1:0] FUNC_BWD = 2'd2;

  localparam int CW  = (TIMER_BITS > 24) ? TIMER_BITS : 24;
  localparam int EXW = (ECHO_BITS > 16) ? ECHO_BITS : 16;
  localparam int DW  = (ECHO_BITS > 17) ? ECHO_BITS : 17;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam logic [ECHO_BITS-1:0]  EMAX = {ECHO_BITS{1'b1}};

  phase_t                phase_r, phase_nxt;
  logic                  bwd_r, bwd_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [ECHO_BITS-1:0]  echo_w_r, echo_w_nxt;
  logic [10:0]           dist_r, dist_nxt;

  logic [TIMER_BITS-1:0] timer_inc;
  logic                  settle_done, pulse_done;
  logic [ECHO_BITS-1:0]  echo_inc;
  logic [DW-1:0]         w_ext;
  logic [16:0]           w_lo;
  logic [34:0]           prod;
  logic [10:0]           quot;
  logic                  fwd_go, bwd_go;
  urac_pkg::drive_t      drive;
  logic                  arrived, dvalid;

  assign timer_inc   = (timer_r == TMAX) ? timer_r : timer_r + 1'b1;
  assign settle_done = (CW'(timer_inc) >= CW'(cfg.settle_need)) || (timer_inc == TMAX);
  assign pulse_done  = (CW'(timer_inc) >= CW'(cfg.pulse_need)) || (timer_inc == TMAX);
  assign echo_inc    = (echo_w_r == EMAX) ? echo_w_r : echo_w_r + 1'b1;

  // width / 58 by reciprocal, saturating at 2047 cm
  assign w_ext = DW'(echo_w_r);
  assign w_lo  = w_ext[16:0];
  assign prod  = 35'(w_lo) * 35'(urac_pkg::DIV_MUL);
  assign quot  = (w_ext >= DW'(urac_pkg::DIST_SAT_W)) ? urac_pkg::DIST_MAX
                                                       : prod[urac_pkg::DIV_SHIFT +: 11];

  assign fwd_go = EXW'(echo_w_r) > EXW'(cfg.fwd_thr);
  assign bwd_go = EXW'(echo_w_r) < EXW'(cfg.bwd_thr);

  always_comb begin
    phase_nxt  = phase_r;
    bwd_nxt    = bwd_r;
    timer_nxt  = timer_r;
    echo_w_nxt = echo_w_r;
    dist_nxt   = dist_r;
    drive      = urac_pkg::DRV_NONE;
    arrived    = 1'b0;
    dvalid     = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (func == FUNC_FWD || func == FUNC_BWD) begin
          bwd_nxt   = (func == FUNC_BWD);
          phase_nxt = PH_SETTLE;
          timer_nxt = '0;
        end
      end
      PH_SETTLE: begin
        timer_nxt = timer_inc;
        if (settle_done) begin
          phase_nxt = PH_PULSE;
          timer_nxt = '0;
        end
      end
      PH_PULSE: begin
        timer_nxt = timer_inc;
        if (pulse_done) begin
          phase_nxt = PH_WAIT;
          timer_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          echo_w_nxt = ECHO_BITS'(1);
          phase_nxt  = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          echo_w_nxt = echo_inc;
        end else begin
          dist_nxt  = quot;
          dvalid    = 1'b1;
          timer_nxt = '0;
          if (!bwd_r) begin
            if (fwd_go) begin
              drive     = urac_pkg::DRV_FWD;
              phase_nxt = PH_SETTLE;
            end else begin
              drive     = urac_pkg::DRV_STOP;
              arrived   = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end else begin
            if (bwd_go) begin
              drive     = urac_pkg::DRV_REV;
              phase_nxt = PH_SETTLE;
            end else begin
              drive     = urac_pkg::DRV_STOP;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bwd_r    <= 1'b0;
      timer_r  <= '0;
      echo_w_r <= '0;
      dist_r   <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      bwd_r    <= bwd_nxt;
      timer_r  <= timer_nxt;
      echo_w_r <= echo_w_nxt;
      dist_r   <= dist_nxt;
    end
  end

  always_comb begin
    res.trigger    = (phase_nxt == PH_PULSE);
    res.drive      = drive;
    res.arrived    = arrived;
    res.dist_cm    = dist_nxt;
    res.dist_valid = dvalid;
    res.busy       = (phase_nxt != PH_IDLE);
  end

endmodule

// ----- rtl/urac_chk.sv -----
`timescale 1ns / 1ps

module urac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_trigger_level,
  input logic [1:0]  out_drive_cmd,
  input logic        out_arrived,
  input logic [10:0] out_distance_cm,
  input logic        out_distance_valid,
  input logic        out_busy_res
);

  // arrival always comes with a stop and an idle sequencer
  a_arrive_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_drive_cmd == urac_pkg::DRV_STOP && !out_busy_res)
    else $error("arrived without stop or while busy");

  // any drive command is issued only on a fresh measurement
  a_drive_meas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_cmd != urac_pkg::DRV_NONE |-> out_distance_valid)
    else $error("drive command without new distance");

  // trigger pulse only within an active ranging loop
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_level |-> out_busy_res && !out_distance_valid)
    else $error("trigger high outside ranging loop");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_cm)
      && $stable(out_drive_cmd))
    else $error("stalled result changed");

endmodule

bind ultrasonic_range_approach_controller urac_chk u_chk (.*);
